// ----- sv/rdm_pkg.sv -----
// ----------------------------------------------------------------------------
// rdm_pkg
// Shared widths, constants and types of the radial distortion point/vector map.
// ----------------------------------------------------------------------------
package rdm_pkg;

  localparam int unsigned CoordW    = 24;
  localparam int unsigned AngleW    = 16;
  localparam int unsigned CfgW      = 16;
  localparam int unsigned CfgIdxW   = 3;
  localparam int unsigned SqW       = 48;
  localparam int unsigned SqHalfW   = 24;
  localparam int unsigned ScaleW    = 36;
  localparam int unsigned PipeDepth = 15;

  // 1e-4 scaled by 2^32
  localparam logic [18:0] E4Q32   = 19'd429497;
  localparam logic [30:0] R2Cap   = {31{1'b1}};
  localparam logic [61:0] TermLim = {1'b1, 61'd0};
  localparam logic [50:0] GainOne = 51'd65536;

  typedef logic signed [CoordW-1:0] coord_t;
  typedef logic [CoordW-1:0]        coord_mag_t;

  localparam coord_t CoordMax = {1'b0, {(CoordW-1){1'b1}}};
  localparam coord_t CoordMin = {1'b1, {(CoordW-1){1'b0}}};

  typedef enum logic [CfgIdxW-1:0] {
    RegQuarticGain = 3'd0,
    RegXBias       = 3'd1,
    RegXRoll       = 3'd2,
    RegYBias       = 3'd3,
    RegYPitch      = 3'd4
  } cfg_reg_e;

  localparam logic [CfgW-1:0]        QuarticGainRst = 16'd9830;
  localparam logic signed [CfgW-1:0] XBiasRst       = -16'sd17;
  localparam logic signed [CfgW-1:0] XRollRst       = 16'sd1809;
  localparam logic signed [CfgW-1:0] YBiasRst       = -16'sd395;
  localparam logic signed [CfgW-1:0] YPitchRst      = 16'sd1821;

  typedef struct packed {
    coord_t     xs;
    coord_t     ys;
    coord_t     vx;
    coord_t     vy;
    coord_mag_t ax;
    coord_mag_t ay;
    coord_mag_t avx;
    coord_mag_t avy;
    logic       sat;
  } carry_t;

endpackage

// ----- sv/rdm_e4_scale.sv -----
// ----------------------------------------------------------------------------
// rdm_e4_scale
// Two-stage scaler: magnitude times 1e-4 into Q.16, split 24-bit partial products.
// ----------------------------------------------------------------------------
module rdm_e4_scale (
  input  logic                        clk_i,
  input  logic [rdm_pkg::SqW-1:0]     mag_i,
  output logic [rdm_pkg::ScaleW-1:0]  scaled_o
);
  import rdm_pkg::*;

  logic [42:0]       hi_prod_d, hi_prod_q;
  logic [42:0]       lo_full;
  logic [18:0]       lo_prod_d, lo_prod_q;
  logic [43:0]       sum;
  logic [ScaleW-1:0] scaled_d, scaled_q;

  always_comb begin
    hi_prod_d = 43'(mag_i[SqW-1:SqHalfW]) * 43'(E4Q32);
    lo_full   = 43'(mag_i[SqHalfW-1:0]) * 43'(E4Q32);
    lo_prod_d = lo_full[42:24];
    sum       = 44'(hi_prod_q) + 44'(lo_prod_q);
    scaled_d  = sum[43:8];
  end

  always_ff @(posedge clk_i) begin
    hi_prod_q <= hi_prod_d;
    lo_prod_q <= lo_prod_d;
    scaled_q  <= scaled_d;
  end

  assign scaled_o = scaled_q;

endmodule

// ----- sv/radial_distortion_point_vector_map_top.sv -----
// ----------------------------------------------------------------------------
// radial_distortion_point_vector_map_top
// Quartic radial distortion of a point and of a vector at that point.
// ----------------------------------------------------------------------------
// Throughput: one item per cycle; busy stays low, the 15-stage multiply
// pipeline takes a new item on every edge and results cannot be held off.
// Reset clears the valid pipeline and loads the register defaults.
module radial_distortion_point_vector_map_top (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start,
  output logic                              busy,
  input  rdm_pkg::coord_t                   point_x_i,
  input  rdm_pkg::coord_t                   point_y_i,
  input  rdm_pkg::coord_t                   vector_x_i,
  input  rdm_pkg::coord_t                   vector_y_i,
  input  logic signed [rdm_pkg::AngleW-1:0] roll_angle_i,
  input  logic signed [rdm_pkg::AngleW-1:0] pitch_angle_i,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [rdm_pkg::CfgIdxW-1:0]       cfg_index_i,
  input  logic [rdm_pkg::CfgW-1:0]          cfg_data_i,
  output logic                              valid_o,
  output rdm_pkg::coord_t                   mapped_x_o,
  output rdm_pkg::coord_t                   mapped_y_o,
  output rdm_pkg::coord_t                   mapped_vx_o,
  output rdm_pkg::coord_t                   mapped_vy_o,
  output logic                              saturated_o
);
  import rdm_pkg::*;

  function automatic coord_mag_t abs_c(coord_t v);
    abs_c = v[CoordW-1] ? coord_mag_t'(-v) : coord_mag_t'(v);
  endfunction

  // configuration
  logic [CfgW-1:0]        k4_d, k4_q;
  logic signed [CfgW-1:0] xbias_d, xbias_q, xroll_d, xroll_q;
  logic signed [CfgW-1:0] ybias_d, ybias_q, ypitch_d, ypitch_q;

  // control
  logic [PipeDepth-1:0] valid_d, valid_q;

  // stage 1
  coord_t             s1_px_d, s1_px_q, s1_py_d, s1_py_q;
  coord_t             s1_vx_d, s1_vx_q, s1_vy_d, s1_vy_q;
  logic signed [31:0] s1_offx_d, s1_offx_q, s1_offy_d, s1_offy_q;

  // stage 2
  logic signed [20:0] offx, offy;
  logic signed [24:0] dx, dy;
  logic               ovx, ovy;

  carry_t carry_d [2:14];
  carry_t carry_q [2:14];

  // stage 3, 4
  logic signed [47:0] xx_d, xx_q, yy_d, yy_q, xv_d, xv_q, yv_d, yv_q;
  logic signed [48:0] dsum, dneg_val;
  logic [SqW-1:0]     sq_d, sq_q, dmag_d, dmag_q;
  logic               dneg_d [4:10];
  logic               dneg_q [4:10];

  // stage 5, 6
  logic [ScaleW-1:0] r2u, dm;

  // stage 7 to 10
  logic [30:0]        r2_d, r2_q;
  logic [ScaleW-1:0]  dm_d [7:8];
  logic [ScaleW-1:0]  dm_q [7:8];
  logic [61:0]        rr_full;
  logic [46:0]        kr_full;
  logic [45:0]        rr_d, rr_q;
  logic [34:0]        kr_d, kr_q;
  logic [36:0]        kr4;
  logic [61:0]        gp_d, gp_q;
  logic [54:0]        rplo_d, rplo_q, rphi_d, rphi_q;
  logic [50:0]        gain_d, gain_q;
  logic [72:0]        rm;
  logic [61:0]        rcap_d, rcap_q;

  // stage 11 to 15
  logic [62:0]        rrnd;
  logic [45:0]        radm_d, radm_q;
  logic               radneg_d [11:13];
  logic               radneg_q [11:13];
  coord_mag_t         opnd [4];
  logic [3:0]         sgn13, sgn14;
  logic [49:0]        gpl_d [4];
  logic [49:0]        gpl_q [4];
  logic [48:0]        gph_d [4];
  logic [48:0]        gph_q [4];
  logic [74:0]        gsum [4];
  logic [61:0]        gt_d [4];
  logic [61:0]        gt_q [4];
  logic [46:0]        rpl_d [2];
  logic [46:0]        rpl_q [2];
  logic [46:0]        rph_d [2];
  logic [46:0]        rph_q [2];
  logic [69:0]        rsum [2];
  logic [61:0]        rt_d [2];
  logic [61:0]        rt_q [2];
  logic signed [62:0] gs_d [4];
  logic signed [62:0] gs_q [4];
  logic signed [62:0] gsp_d [4];
  logic signed [62:0] gsp_q [4];
  logic signed [62:0] rs_d [2];
  logic signed [62:0] rs_q [2];
  logic signed [63:0] osum [4];
  logic signed [47:0] oq [4];
  logic [3:0]         oov;
  coord_t             out_d [4];
  coord_t             out_q [4];
  logic               sat_d, sat_q;

  assign busy        = 1'b0;
  assign cfg_ready_o = 1'b1;

  // configuration registers
  always_comb begin
    k4_d     = k4_q;
    xbias_d  = xbias_q;
    xroll_d  = xroll_q;
    ybias_d  = ybias_q;
    ypitch_d = ypitch_q;
    if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        RegQuarticGain: k4_d     = cfg_data_i;
        RegXBias:       xbias_d  = $signed(cfg_data_i);
        RegXRoll:       xroll_d  = $signed(cfg_data_i);
        RegYBias:       ybias_d  = $signed(cfg_data_i);
        RegYPitch:      ypitch_d = $signed(cfg_data_i);
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      k4_q     <= QuarticGainRst;
      xbias_q  <= XBiasRst;
      xroll_q  <= XRollRst;
      ybias_q  <= YBiasRst;
      ypitch_q <= YPitchRst;
      valid_q  <= '0;
    end else begin
      k4_q     <= k4_d;
      xbias_q  <= xbias_d;
      xroll_q  <= xroll_d;
      ybias_q  <= ybias_d;
      ypitch_q <= ypitch_d;
      valid_q  <= valid_d;
    end
  end

  assign valid_d = {valid_q[PipeDepth-2:0], start && !busy};

  // stages 1 to 4: offset, shift and clamp, products, sums
  always_comb begin
    s1_px_d   = point_x_i;
    s1_py_d   = point_y_i;
    s1_vx_d   = vector_x_i;
    s1_vy_d   = vector_y_i;
    s1_offx_d = 32'(xroll_q) * 32'(roll_angle_i);
    s1_offy_d = 32'(ypitch_q) * 32'(pitch_angle_i);

    offx = 21'(xbias_q) + 21'($signed(s1_offx_q[31:12]));
    offy = 21'(ybias_q) + 21'($signed(s1_offy_q[31:12]));
    dx   = 25'(s1_px_q) - 25'(offx);
    dy   = 25'(s1_py_q) - 25'(offy);
    ovx  = dx[24] != dx[23];
    ovy  = dy[24] != dy[23];

    carry_d[2]     = '0;
    carry_d[2].xs  = ovx ? (dx[24] ? CoordMin : CoordMax) : $signed(dx[23:0]);
    carry_d[2].ys  = ovy ? (dy[24] ? CoordMin : CoordMax) : $signed(dy[23:0]);
    carry_d[2].vx  = s1_vx_q;
    carry_d[2].vy  = s1_vy_q;
    carry_d[2].sat = ovx || ovy;

    carry_d[3]     = carry_q[2];
    carry_d[3].ax  = abs_c(carry_q[2].xs);
    carry_d[3].ay  = abs_c(carry_q[2].ys);
    carry_d[3].avx = abs_c(carry_q[2].vx);
    carry_d[3].avy = abs_c(carry_q[2].vy);
    for (int k = 4; k <= 14; k++) begin
      carry_d[k] = carry_q[k-1];
    end

    xx_d = 48'($signed(carry_q[2].xs)) * 48'($signed(carry_q[2].xs));
    yy_d = 48'($signed(carry_q[2].ys)) * 48'($signed(carry_q[2].ys));
    xv_d = 48'($signed(carry_q[2].xs)) * 48'($signed(carry_q[2].vx));
    yv_d = 48'($signed(carry_q[2].ys)) * 48'($signed(carry_q[2].vy));

    sq_d      = $unsigned(xx_q + yy_q);
    dsum      = 49'(xv_q) + 49'(yv_q);
    dneg_val  = -dsum;
    dneg_d[4] = dsum[48];
    dmag_d    = dsum[48] ? dneg_val[SqW-1:0] : dsum[SqW-1:0];
    for (int k = 5; k <= 10; k++) begin
      dneg_d[k] = dneg_q[k-1];
    end
  end

  rdm_e4_scale u_r2_scale (
    .clk_i    (clk_i),
    .mag_i    (sq_q),
    .scaled_o (r2u)
  );

  rdm_e4_scale u_dot_scale (
    .clk_i    (clk_i),
    .mag_i    (dmag_q),
    .scaled_o (dm)
  );

  // stages 7 to 10: r2 cap, gain and radial products
  always_comb begin
    r2_d    = (r2u > ScaleW'(R2Cap)) ? R2Cap : r2u[30:0];
    dm_d[7] = dm;
    dm_d[8] = dm_q[7];

    rr_full = 62'(r2_q) * 62'(r2_q);
    kr_full = 47'(k4_q) * 47'(r2_q);
    rr_d    = rr_full[61:16];
    kr_d    = kr_full[46:12];

    kr4    = {kr_q, 2'b00};
    gp_d   = 62'(rr_q) * 62'(k4_q);
    rplo_d = 55'(kr4) * 55'(dm_q[8][17:0]);
    rphi_d = 55'(kr4) * 55'(dm_q[8][35:18]);

    gain_d = GainOne + 51'(gp_q[61:12]);
    rm     = 73'(rplo_q) + (73'(rphi_q) << 18);
    rcap_d = (rm > 73'(TermLim)) ? TermLim : rm[61:0];
  end

  // stages 11 to 15: output terms, sums and clamp
  always_comb begin
    rrnd         = 63'(rcap_q) + 63'(16'hFFFF);
    radm_d       = dneg_q[10] ? rrnd[61:16] : rcap_q[61:16];
    radneg_d[11] = dneg_q[10];
    radneg_d[12] = radneg_q[11];
    radneg_d[13] = radneg_q[12];

    opnd[0] = carry_q[10].ax;
    opnd[1] = carry_q[10].ay;
    opnd[2] = carry_q[10].avx;
    opnd[3] = carry_q[10].avy;
    sgn13   = {carry_q[12].vy[CoordW-1], carry_q[12].vx[CoordW-1],
               carry_q[12].ys[CoordW-1], carry_q[12].xs[CoordW-1]};
    sgn14   = {carry_q[13].vy[CoordW-1], carry_q[13].vx[CoordW-1],
               carry_q[13].ys[CoordW-1], carry_q[13].xs[CoordW-1]};

    for (int i = 0; i < 4; i++) begin
      gpl_d[i] = 50'(gain_q[25:0]) * 50'(opnd[i]);
      gph_d[i] = 49'(gain_q[50:26]) * 49'(opnd[i]);
      gsum[i]  = 75'(gpl_q[i]) + (75'(gph_q[i]) << 26);
      gt_d[i]  = (gsum[i] > 75'(TermLim)) ? TermLim : gsum[i][61:0];
      gs_d[i]  = sgn13[i] ? -$signed(63'(gt_q[i])) : $signed(63'(gt_q[i]));
      gsp_d[i] = gs_q[i];
    end

    rpl_d[0] = 47'(radm_q[22:0]) * 47'(carry_q[11].ax);
    rph_d[0] = 47'(radm_q[45:23]) * 47'(carry_q[11].ax);
    rpl_d[1] = 47'(radm_q[22:0]) * 47'(carry_q[11].ay);
    rph_d[1] = 47'(radm_q[45:23]) * 47'(carry_q[11].ay);
    for (int i = 0; i < 2; i++) begin
      rsum[i] = 70'(rpl_q[i]) + (70'(rph_q[i]) << 23);
      rt_d[i] = (rsum[i] > 70'(TermLim)) ? TermLim : rsum[i][61:0];
      rs_d[i] = (radneg_q[13] ^ sgn14[i]) ? -$signed(63'(rt_q[i]))
                                          : $signed(63'(rt_q[i]));
    end

    osum[0] = 64'(gsp_q[0]);
    osum[1] = 64'(gsp_q[1]);
    osum[2] = 64'(gsp_q[2]) + 64'(rs_q[0]);
    osum[3] = 64'(gsp_q[3]) + 64'(rs_q[1]);
    for (int i = 0; i < 4; i++) begin
      oq[i]    = osum[i][63:16];
      oov[i]   = !((&oq[i][47:23]) || !(|oq[i][47:23]));
      out_d[i] = oov[i] ? (oq[i][47] ? CoordMin : CoordMax) : $signed(oq[i][23:0]);
    end
    sat_d = carry_q[14].sat || (|oov);
  end

  always_ff @(posedge clk_i) begin
    s1_px_q   <= s1_px_d;
    s1_py_q   <= s1_py_d;
    s1_vx_q   <= s1_vx_d;
    s1_vy_q   <= s1_vy_d;
    s1_offx_q <= s1_offx_d;
    s1_offy_q <= s1_offy_d;
    carry_q   <= carry_d;
    xx_q      <= xx_d;
    yy_q      <= yy_d;
    xv_q      <= xv_d;
    yv_q      <= yv_d;
    sq_q      <= sq_d;
    dmag_q    <= dmag_d;
    dneg_q    <= dneg_d;
    r2_q      <= r2_d;
    dm_q      <= dm_d;
    rr_q      <= rr_d;
    kr_q      <= kr_d;
    gp_q      <= gp_d;
    rplo_q    <= rplo_d;
    rphi_q    <= rphi_d;
    gain_q    <= gain_d;
    rcap_q    <= rcap_d;
    radm_q    <= radm_d;
    radneg_q  <= radneg_d;
    gpl_q     <= gpl_d;
    gph_q     <= gph_d;
    gt_q      <= gt_d;
    rpl_q     <= rpl_d;
    rph_q     <= rph_d;
    rt_q      <= rt_d;
    gs_q      <= gs_d;
    gsp_q     <= gsp_d;
    rs_q      <= rs_d;
    out_q     <= out_d;
    sat_q     <= sat_d;
  end

  assign valid_o     = valid_q[PipeDepth-1];
  assign mapped_x_o  = out_q[0];
  assign mapped_y_o  = out_q[1];
  assign mapped_vx_o = out_q[2];
  assign mapped_vy_o = out_q[3];
  assign saturated_o = sat_q;

  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> $past(start && !busy, PipeDepth))
    else $error("result without an item accepted one latency earlier");

  a_gain_floor: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q[9] |-> (gain_q >= GainOne))
    else $error("radial gain below unity");

  a_radial_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q[9] |-> (rcap_q <= TermLim))
    else $error("radial product above term limit");

endmodule

// ----- test/radial_distortion_point_vector_map_top_test.sv -----
// ----------------------------------------------------------------------------
// radial_distortion_point_vector_map_top_test
// Self-checking bench for the quartic radial distortion point/vector map.
// Drives directed corner items and then random items under several register
// settings. A bit-true predictor computes each expected result, and the
// monitor compares every strobed result field by field, in order.
// ----------------------------------------------------------------------------
module radial_distortion_point_vector_map_top_test;
  timeunit 1ns;
  timeprecision 1ps;

  import rdm_pkg::*;

  typedef logic signed [AngleW-1:0] angle_t;

  typedef struct packed {
    coord_t px;
    coord_t py;
    coord_t vx;
    coord_t vy;
    angle_t roll;
    angle_t pitch;
  } point_item_t;

  typedef struct packed {
    coord_t x;
    coord_t y;
    coord_t vx;
    coord_t vy;
    logic   sat;
  } mapped_t;

  localparam logic [CfgIdxW-1:0] RegUnused = 3'd7;
  localparam longint CoordHi = (longint'(1) <<< (CoordW - 1)) - 1;
  localparam longint CoordLo = -(longint'(1) <<< (CoordW - 1));

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start = 1'b0;
  logic busy;
  coord_t point_x_i = '0;
  coord_t point_y_i = '0;
  coord_t vector_x_i = '0;
  coord_t vector_y_i = '0;
  angle_t roll_angle_i = '0;
  angle_t pitch_angle_i = '0;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [CfgIdxW-1:0] cfg_index_i = '0;
  logic [CfgW-1:0] cfg_data_i = '0;
  logic valid_o;
  coord_t mapped_x_o;
  coord_t mapped_y_o;
  coord_t mapped_vx_o;
  coord_t mapped_vy_o;
  logic saturated_o;

  logic [CfgW-1:0]        k4_reg     = QuarticGainRst;
  logic signed [CfgW-1:0] xbias_reg  = XBiasRst;
  logic signed [CfgW-1:0] xroll_reg  = XRollRst;
  logic signed [CfgW-1:0] ybias_reg  = YBiasRst;
  logic signed [CfgW-1:0] ypitch_reg = YPitchRst;

  point_item_t points_pending[$];
  mapped_t     mapped_expected[$];
  point_item_t point_on_port;
  bit          item_live = 1'b0;
  int unsigned idle_pct = 0;
  int          err_count = 0;

  radial_distortion_point_vector_map_top DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start        (start),
    .busy         (busy),
    .point_x_i    (point_x_i),
    .point_y_i    (point_y_i),
    .vector_x_i   (vector_x_i),
    .vector_y_i   (vector_y_i),
    .roll_angle_i (roll_angle_i),
    .pitch_angle_i(pitch_angle_i),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .valid_o      (valid_o),
    .mapped_x_o   (mapped_x_o),
    .mapped_y_o   (mapped_y_o),
    .mapped_vx_o  (mapped_vx_o),
    .mapped_vy_o  (mapped_vy_o),
    .saturated_o  (saturated_o)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  function automatic longint unsigned mul_1e4(longint unsigned m);
    longint unsigned t;
    t = (m >> 24) * 64'd429497 + (((m & 64'hFF_FFFF) * 64'd429497) >> 24);
    return t >> 8;
  endfunction

  function automatic longint capped_mul(longint a, longint b);
    longint unsigned ua, ub, m;
    ua = (a < 0) ? -a : a;
    ub = (b < 0) ? -b : b;
    if (ua != 0 && ub > 64'(TermLim) / ua) begin
      m = 64'(TermLim);
    end else begin
      m = ua * ub;
      if (m > 64'(TermLim)) m = 64'(TermLim);
    end
    return ((a < 0) != (b < 0)) ? -longint'(m) : longint'(m);
  endfunction

  function automatic longint clip_coord(longint v);
    if (v > CoordHi) return CoordHi;
    if (v < CoordLo) return CoordLo;
    return v;
  endfunction

  function automatic mapped_t distort_point_vector(point_item_t it);
    longint px, py, vx, vy, roll, pitch, k4;
    longint ox, oy, t, xs, ys, r2, gain, ds, d, kr, radial;
    longint c0, c1, c2, c3;
    longint unsigned r2u, dm;
    mapped_t res;
    logic sat;
    px = longint'(it.px);
    py = longint'(it.py);
    vx = longint'(it.vx);
    vy = longint'(it.vy);
    roll = longint'(it.roll);
    pitch = longint'(it.pitch);
    k4 = longint'(k4_reg);
    sat = 1'b0;
    ox = longint'(xbias_reg) + ((longint'(xroll_reg) * roll) >>> 12);
    oy = longint'(ybias_reg) + ((longint'(ypitch_reg) * pitch) >>> 12);
    t = px - ox;
    xs = clip_coord(t);
    if (xs != t) sat = 1'b1;
    t = py - oy;
    ys = clip_coord(t);
    if (ys != t) sat = 1'b1;
    r2u = mul_1e4(xs * xs + ys * ys);
    r2 = (r2u > 64'(R2Cap)) ? longint'(64'(R2Cap)) : longint'(r2u);
    gain = 65536 + ((((r2 * r2) >>> 16) * k4) >>> 12);
    ds = xs * vx + ys * vy;
    dm = mul_1e4((ds < 0) ? -ds : ds);
    d = longint'(dm);
    if (ds < 0) d = -d;
    kr = (k4 * r2) >>> 12;
    radial = capped_mul(4 * kr, d) >>> 16;
    c0 = clip_coord(capped_mul(gain, xs) >>> 16);
    c1 = clip_coord(capped_mul(gain, ys) >>> 16);
    c2 = clip_coord((capped_mul(gain, vx) + capped_mul(radial, xs)) >>> 16);
    c3 = clip_coord((capped_mul(gain, vy) + capped_mul(radial, ys)) >>> 16);
    if (c0 != (capped_mul(gain, xs) >>> 16)) sat = 1'b1;
    if (c1 != (capped_mul(gain, ys) >>> 16)) sat = 1'b1;
    if (c2 != ((capped_mul(gain, vx) + capped_mul(radial, xs)) >>> 16)) sat = 1'b1;
    if (c3 != ((capped_mul(gain, vy) + capped_mul(radial, ys)) >>> 16)) sat = 1'b1;
    res.x = c0[CoordW-1:0];
    res.y = c1[CoordW-1:0];
    res.vx = c2[CoordW-1:0];
    res.vy = c3[CoordW-1:0];
    res.sat = sat;
    return res;
  endfunction

  // drive one item per accepted handshake, idle between items at random
  always @(posedge clk_i) begin
    if (start && !busy) begin
      mapped_expected.push_back(distort_point_vector(point_on_port));
      item_live = 1'b0;
    end
    if (!item_live && points_pending.size() != 0 && $urandom_range(99) >= idle_pct) begin
      point_on_port = points_pending.pop_front();
      item_live = 1'b1;
      point_x_i <= point_on_port.px;
      point_y_i <= point_on_port.py;
      vector_x_i <= point_on_port.vx;
      vector_y_i <= point_on_port.vy;
      roll_angle_i <= point_on_port.roll;
      pitch_angle_i <= point_on_port.pitch;
    end
    start <= item_live;
  end

  task automatic check_field(input string name, input logic signed [31:0] want,
                             input logic signed [31:0] got);
    if (got !== want) begin
      $display("%0t: %s expected %0d actual %0d", $time, name, want, got);
      err_count++;
    end
  endtask

  always @(posedge clk_i) begin
    mapped_t want;
    if (rst_ni && valid_o) begin
      if (mapped_expected.size() == 0) begin
        $display("%0t: result with no item pending, expected none actual x=%0d y=%0d",
                 $time, mapped_x_o, mapped_y_o);
        err_count++;
      end else begin
        want = mapped_expected.pop_front();
        check_field("mapped_x", 32'(want.x), 32'(mapped_x_o));
        check_field("mapped_y", 32'(want.y), 32'(mapped_y_o));
        check_field("mapped_vx", 32'(want.vx), 32'(mapped_vx_o));
        check_field("mapped_vy", 32'(want.vy), 32'(mapped_vy_o));
        check_field("saturated", {31'd0, want.sat}, {31'd0, saturated_o});
      end
    end
  end

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgW-1:0] value);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    case (idx)
      RegQuarticGain: k4_reg = value;
      RegXBias:       xbias_reg = value;
      RegXRoll:       xroll_reg = value;
      RegYBias:       ybias_reg = value;
      RegYPitch:      ypitch_reg = value;
      default: ;
    endcase
  endtask

  task automatic load_config(input logic [CfgW-1:0] k4, xb, xr, yb, yp);
    write_reg(RegQuarticGain, k4);
    write_reg(RegXBias, xb);
    write_reg(RegXRoll, xr);
    write_reg(RegYBias, yb);
    write_reg(RegYPitch, yp);
  endtask

  task automatic drain();
    while (points_pending.size() != 0 || item_live || mapped_expected.size() != 0)
      @(posedge clk_i);
  endtask

  task automatic push_point(input coord_t px, py, vx, vy, input angle_t roll, pitch);
    point_item_t it;
    it.px = px;
    it.py = py;
    it.vx = vx;
    it.vy = vy;
    it.roll = roll;
    it.pitch = pitch;
    points_pending.push_back(it);
  endtask

  function automatic coord_t random_coord();
    int unsigned r;
    int v;
    r = $urandom_range(19);
    if (r < 7) begin
      v = $urandom_range(65535);
      return coord_t'(v - 32768);
    end else if (r < 14) begin
      v = $urandom_range(262143);
      return coord_t'(v - 131072);
    end else if (r < 18) begin
      return coord_t'($urandom);
    end
    case ($urandom_range(4))
      0: return CoordMax;
      1: return CoordMin;
      2: return 0;
      3: return -1;
      default: return 1;
    endcase
  endfunction

  function automatic angle_t random_angle();
    int unsigned r;
    int v;
    r = $urandom_range(9);
    if (r < 6) begin
      v = $urandom_range(4095);
      return angle_t'(v - 2048);
    end else if (r < 9) begin
      return angle_t'($urandom);
    end
    case ($urandom_range(2))
      0: return 16'sh7FFF;
      1: return 16'sh8000;
      default: return 0;
    endcase
  endfunction

  task automatic queue_random(input int count);
    repeat (count)
      push_point(random_coord(), random_coord(), random_coord(), random_coord(),
                 random_angle(), random_angle());
  endtask

  initial begin
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    push_point(0, 0, 0, 0, 0, 0);
    push_point(256 * 100, 256 * 50, 256 * 3, -256 * 2, 0, 0);
    push_point(-256 * 80, 256 * 120, -256, 256 * 4, 256 * 5, -256 * 5);
    push_point(CoordMax, CoordMax, CoordMax, CoordMax, 16'sh7FFF, 16'sh7FFF);
    push_point(CoordMin, CoordMin, CoordMin, CoordMin, 16'sh8000, 16'sh8000);
    push_point(CoordMin, CoordMax, CoordMax, CoordMin, 16'sh7FFF, 16'sh8000);
    push_point(CoordMax, CoordMin, CoordMin, CoordMax, 16'sh8000, 16'sh7FFF);
    push_point(-17, -395, 256 * 10, 256 * 10, 0, 0);
    push_point(256 * 2000, 256 * 2000, 256, 256, 0, 0);
    push_point(256 * 300, -256 * 200, 256 * 50, 256 * 50, 256, -256);
    push_point(0, 0, CoordMax, CoordMin, 0, 0);
    push_point(256 * 100, 0, CoordMax, CoordMax, 0, 0);
    push_point(1, -1, -1, 1, 1, -1);
    push_point(-1, -1, -1, -1, -1, -1);
    push_point(256 * 50, 256 * 50, CoordMin, CoordMin, 256 * 127, -256 * 127);
    push_point(256 * 150, -256 * 150, -256 * 20, 256 * 20, 0, 0);
    drain();

    write_reg(RegUnused, CfgW'($urandom));
    idle_pct = 9;
    queue_random(250);
    drain();

    load_config(16'hFFFF, 16'h7FFF, 16'h7FFF, 16'h8000, 16'h8000);
    queue_random(125);
    drain();

    load_config(CfgW'($urandom), CfgW'($urandom), CfgW'($urandom), CfgW'($urandom),
                CfgW'($urandom));
    queue_random(200);
    drain();

    idle_pct = 80;
    load_config(16'h0000, 16'h8000, 16'h8000, 16'h7FFF, 16'h7FFF);
    queue_random(125);
    drain();

    load_config(CfgW'($urandom), CfgW'($urandom), CfgW'($urandom), CfgW'($urandom),
                CfgW'($urandom));
    queue_random(200);
    drain();

    idle_pct = 0;
    load_config(CfgW'($urandom), CfgW'($urandom), CfgW'($urandom), CfgW'($urandom),
                CfgW'($urandom));
    queue_random(200);
    drain();

    load_config(QuarticGainRst, XBiasRst, XRollRst, YBiasRst, YPitchRst);
    queue_random(150);
    drain();

    repeat (20) @(posedge clk_i);
    if (err_count == 0) begin
      $display("PASS radial_distortion_point_vector_map_top");
    end else begin
      $display("FAIL radial_distortion_point_vector_map_top");
    end
    $finish;
  end

  initial begin
    #6_000_000;
    $display("FAIL radial_distortion_point_vector_map_top");
    $finish;
  end

endmodule
